// ===== hdl/lsb_pkg.sv =====
package lsb_pkg;

    // Default sinogram geometry and counter width
    localparam int S_BINS_DEF      = 512;
    localparam int THETA_BINS_DEF  = 512;
    localparam int COUNT_WIDTH_DEF = 32;

    // Field widths of the stream payloads
    localparam int PID_W       = 32;
    localparam int POS_W       = 24;
    localparam int DIR_W       = 16;
    localparam int BIN_W       = 9;
    localparam int THETA_W     = 16;
    localparam int OUT_CNT_W   = 32;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 96;

    localparam logic [PID_W-1:0] CODE_RESET = 32'd22;

    // Request kinds carried on s_tuser
    localparam logic [0:0] CMD_BIN  = 1'b0;
    localparam logic [0:0] CMD_READ = 1'b1;

    // Iteration counts of the shared units
    localparam int MUL_STEPS    = 11;
    localparam int SQRT_STEPS   = 24;
    localparam int CORDIC_STEPS = 20;

    // Distance limits in Q15.8
    localparam logic [POS_W-1:0] S_MAX_Q   = 24'h7F_FFFF;
    localparam logic [POS_W:0]   S_NEG_LIM = 25'h080_0000;
    localparam logic [POS_W:0]   S_HALF_RANGE = 25'd65536;

    localparam logic [THETA_W-1:0] TURN_HALF    = 16'h8000;
    localparam logic [THETA_W-1:0] TURN_QUARTER = 16'h4000;
    localparam logic [31:0]        ANG_HALF     = 32'h8000_0000;
    localparam logic [31:0]        ANG_ROUND    = 32'h0000_8000;

    // Multiply sequencer steps: a step picks operands, folds in the previous product, or both
    typedef enum logic [3:0] {
        MS_NONE,
        MS_XDZ,
        MS_ZDX,
        MS_XDX,
        MS_ZDZ,
        MS_DXDX,
        MS_DZDZ,
        MS_ABS,
        MS_HH,
        MS_HL,
        MS_LL,
        MS_CSQ
    } mstep_t;

    typedef struct packed {
        logic       load;
        logic       clr_wr;
        mstep_t     mstep;
        logic       it_init;
        logic       it_run;
        logic [4:0] it_k;
        logic       fin;
        logic       mem_rd;
        logic       commit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic clr_last;
        logic out_free;
    } dp_stat_t;

    // CORDIC arctangent table in 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:    r = 32'h2000_0000;
            5'd1:    r = 32'h12E4_051D;
            5'd2:    r = 32'h09FB_385B;
            5'd3:    r = 32'h0511_11D4;
            5'd4:    r = 32'h028B_0D43;
            5'd5:    r = 32'h0145_D7E1;
            5'd6:    r = 32'h00A2_F61E;
            5'd7:    r = 32'h0051_7C55;
            5'd8:    r = 32'h0028_BE53;
            5'd9:    r = 32'h0014_5F2F;
            5'd10:   r = 32'h000A_2F98;
            5'd11:   r = 32'h0005_17CC;
            5'd12:   r = 32'h0002_8BE6;
            5'd13:   r = 32'h0001_45F3;
            5'd14:   r = 32'h0000_A2FA;
            5'd15:   r = 32'h0000_517D;
            5'd16:   r = 32'h0000_28BE;
            5'd17:   r = 32'h0000_145F;
            5'd18:   r = 32'h0000_0A30;
            5'd19:   r = 32'h0000_0518;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/lsb_ctrl.sv =====
module lsb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsb_pkg::dp_stat_t stat,
    output lsb_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISP,
        ST_MUL,
        ST_INIT,
        ST_ITER,
        ST_FIN,
        ST_RD
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [4:0] k_reg, k_next;
    logic       upd_reg, upd_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            k_reg     <= '0;
            upd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            upd_reg   <= upd_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        upd_next   = upd_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mstep  = lsb_pkg::MS_NONE;
        cmd.it_k   = k_reg;
        if (upd_reg) begin
            // hold the finished request until the output register is free
            if (stat.out_free) begin
                cmd.commit = 1'b1;
                upd_next   = 1'b0;
                state_next = ST_IDLE;
            end
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    cmd.clr_wr = 1'b1;
                    if (stat.clr_last) begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    in_ready = 1'b1;
                    if (in_valid) begin
                        cmd.load   = 1'b1;
                        state_next = ST_DISP;
                    end
                end
                ST_DISP: begin
                    step_next = '0;
                    if (stat.is_read) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
                ST_MUL: begin
                    unique case (step_reg)
                        4'd0:    cmd.mstep = lsb_pkg::MS_XDZ;
                        4'd1:    cmd.mstep = lsb_pkg::MS_ZDX;
                        4'd2:    cmd.mstep = lsb_pkg::MS_XDX;
                        4'd3:    cmd.mstep = lsb_pkg::MS_ZDZ;
                        4'd4:    cmd.mstep = lsb_pkg::MS_DXDX;
                        4'd5:    cmd.mstep = lsb_pkg::MS_DZDZ;
                        4'd6:    cmd.mstep = lsb_pkg::MS_ABS;
                        4'd7:    cmd.mstep = lsb_pkg::MS_HH;
                        4'd8:    cmd.mstep = lsb_pkg::MS_HL;
                        4'd9:    cmd.mstep = lsb_pkg::MS_LL;
                        4'd10:   cmd.mstep = lsb_pkg::MS_CSQ;
                        default: cmd.mstep = lsb_pkg::MS_NONE;
                    endcase
                    if (step_reg == 4'(lsb_pkg::MUL_STEPS - 1)) begin
                        state_next = ST_INIT;
                    end else begin
                        step_next = step_reg + 4'd1;
                    end
                end
                ST_INIT: begin
                    cmd.it_init = 1'b1;
                    k_next      = '0;
                    state_next  = ST_ITER;
                end
                ST_ITER: begin
                    cmd.it_run = 1'b1;
                    if (k_reg == 5'(lsb_pkg::SQRT_STEPS - 1)) begin
                        state_next = ST_FIN;
                    end else begin
                        k_next = k_reg + 5'd1;
                    end
                end
                ST_FIN: begin
                    cmd.fin    = 1'b1;
                    state_next = ST_RD;
                end
                ST_RD: begin
                    cmd.mem_rd = 1'b1;
                    upd_next   = 1'b1;
                end
                default: state_next = ST_CLEAR;
            endcase
        end
    end

endmodule

// ===== hdl/lsb_dp.sv =====
module lsb_dp #(
    parameter int S_BINS      = lsb_pkg::S_BINS_DEF,
    parameter int THETA_BINS  = lsb_pkg::THETA_BINS_DEF,
    parameter int COUNT_WIDTH = lsb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic        [lsb_pkg::PID_W-1:0]   cfg_wr_data,
    input  lsb_pkg::dp_cmd_t                   cmd,
    output lsb_pkg::dp_stat_t                  stat,
    input  logic                               in_command,
    input  logic        [lsb_pkg::PID_W-1:0]   in_particle_id,
    input  logic signed [lsb_pkg::POS_W-1:0]   in_pos_x,
    input  logic signed [lsb_pkg::POS_W-1:0]   in_pos_z,
    input  logic signed [lsb_pkg::DIR_W-1:0]   in_dir_x,
    input  logic signed [lsb_pkg::DIR_W-1:0]   in_dir_z,
    input  logic        [lsb_pkg::BIN_W-1:0]   in_read_s_bin,
    input  logic        [lsb_pkg::BIN_W-1:0]   in_read_theta_bin,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_accepted,
    output logic signed [lsb_pkg::POS_W-1:0]   out_s_value,
    output logic        [lsb_pkg::THETA_W-1:0] out_theta_value,
    output logic        [lsb_pkg::BIN_W-1:0]   out_s_bin,
    output logic        [lsb_pkg::BIN_W-1:0]   out_theta_bin,
    output logic                               out_in_range,
    output logic        [lsb_pkg::OUT_CNT_W-1:0] out_bin_count
);

    localparam int DEPTH = S_BINS * THETA_BINS;
    localparam int AW    = $clog2(DEPTH);

    // captured request
    logic                      cmd_reg;
    logic [31:0]               pid_reg;
    logic signed [23:0]        x_reg, z_reg;
    logic signed [15:0]        dx_reg, dz_reg;
    logic [8:0]                rs_reg, rt_reg;
    logic [31:0]               code_reg;

    // shared multiplier and accumulators
    logic signed [24:0]        a_op, b_op;
    logic signed [49:0]        prod_reg;
    logic signed [40:0]        c_reg;
    logic signed [41:0]        dot_reg;
    logic [31:0]               d_reg;
    logic [39:0]               cabs_reg;
    logic [79:0]               csq_reg;
    logic signed [40:0]        c_abs;

    // distance root and angle units
    logic [23:0]               q_reg;
    logic signed [85:0]        p_reg;
    logic signed [57:0]        r_reg;
    logic signed [34:0]        cx_reg, cy_reg;
    logic [31:0]               ang_reg;
    logic [5:0]                bsh;
    logic signed [85:0]        p_try, csq4;
    logic signed [16:0]        x0, y0;
    logic signed [34:0]        cx_sh, cy_sh;

    // finishing stage
    logic                      hz, vt, xnz, znz, cnz, dnz, sp, sn, match, acc, ev_in, rd_ok;
    logic [24:0]               xabs, zabs, mag, smag, sneg;
    logic [15:0]               th0, th_ev, th_cd;
    logic [31:0]               ang_sum, sb_full, tb_full, a_ev, a_rd;
    logic signed [23:0]        zs, s_ev;
    logic signed [24:0]        s_ofs;

    logic                      acc_reg, inr_reg, rdok_reg;
    logic signed [23:0]        s_reg;
    logic [15:0]               th_reg;
    logic [8:0]                sbo_reg, tbo_reg;
    logic [AW-1:0]             addr_reg, clr_addr_reg;

    logic [COUNT_WIDTH-1:0]    mem [DEPTH];
    logic [COUNT_WIDTH-1:0]    rdata_reg, cnt_new;
    logic                      out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg <= lsb_pkg::CODE_RESET;
        end else if (cfg_wr_en) begin
            code_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_command;
            pid_reg <= in_particle_id;
            x_reg   <= in_pos_x;
            z_reg   <= in_pos_z;
            dx_reg  <= in_dir_x;
            dz_reg  <= in_dir_z;
            rs_reg  <= in_read_s_bin;
            rt_reg  <= in_read_theta_bin;
        end
    end

    // operand select
    always_comb begin
        a_op = '0;
        b_op = '0;
        unique case (cmd.mstep)
            lsb_pkg::MS_XDZ:  begin a_op = 25'(x_reg);  b_op = 25'(dz_reg); end
            lsb_pkg::MS_ZDX:  begin a_op = 25'(z_reg);  b_op = 25'(dx_reg); end
            lsb_pkg::MS_XDX:  begin a_op = 25'(x_reg);  b_op = 25'(dx_reg); end
            lsb_pkg::MS_ZDZ:  begin a_op = 25'(z_reg);  b_op = 25'(dz_reg); end
            lsb_pkg::MS_DXDX: begin a_op = 25'(dx_reg); b_op = 25'(dx_reg); end
            lsb_pkg::MS_DZDZ: begin a_op = 25'(dz_reg); b_op = 25'(dz_reg); end
            lsb_pkg::MS_HH: begin
                a_op = $signed({5'd0, cabs_reg[39:20]});
                b_op = $signed({5'd0, cabs_reg[39:20]});
            end
            lsb_pkg::MS_HL: begin
                a_op = $signed({5'd0, cabs_reg[39:20]});
                b_op = $signed({5'd0, cabs_reg[19:0]});
            end
            lsb_pkg::MS_LL: begin
                a_op = $signed({5'd0, cabs_reg[19:0]});
                b_op = $signed({5'd0, cabs_reg[19:0]});
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign c_abs = c_reg[40] ? -c_reg : c_reg;

    // multiply, then fold the previous product into its accumulator
    always_ff @(posedge aclk) begin
        prod_reg <= a_op * b_op;
        case (cmd.mstep)
            lsb_pkg::MS_ZDX:  c_reg   <= 41'(prod_reg);
            lsb_pkg::MS_XDX:  c_reg   <= c_reg - 41'(prod_reg);
            lsb_pkg::MS_ZDZ:  dot_reg <= 42'(prod_reg);
            lsb_pkg::MS_DXDX: dot_reg <= dot_reg + 42'(prod_reg);
            lsb_pkg::MS_DZDZ: d_reg   <= prod_reg[31:0];
            lsb_pkg::MS_ABS: begin
                d_reg    <= d_reg + prod_reg[31:0];
                cabs_reg <= c_abs[39:0];
            end
            lsb_pkg::MS_HL:   csq_reg <= {prod_reg[39:0], 40'd0};
            lsb_pkg::MS_LL:   csq_reg <= csq_reg + (80'(prod_reg[40:0]) << 21);
            lsb_pkg::MS_CSQ:  csq_reg <= csq_reg + 80'(prod_reg[39:0]);
            default: ;
        endcase
    end

    // root digit trial: (2t-1)^2*D built from running terms, compared with 4c^2
    assign bsh   = 6'(lsb_pkg::SQRT_STEPS - 1) - 6'(cmd.it_k);
    assign p_try = p_reg + (86'(r_reg) <<< (bsh + 6'd2))
                 + $signed(86'(d_reg) << ({bsh, 1'b0} + 7'd2));
    assign csq4  = $signed({4'd0, csq_reg, 2'b00});

    // angle unit start vector
    assign y0 = (!c_reg[40] && c_reg != '0) ? 17'(dz_reg) : -17'(dz_reg);
    assign x0 = (!c_reg[40] && c_reg != '0) ? -17'(dx_reg) : 17'(dx_reg);
    assign cx_sh = cx_reg >>> cmd.it_k;
    assign cy_sh = cy_reg >>> cmd.it_k;

    always_ff @(posedge aclk) begin
        if (cmd.it_init) begin
            q_reg <= '0;
            p_reg <= $signed(86'(d_reg));
            r_reg <= -$signed(58'(d_reg));
            if (x0[16]) begin
                cx_reg  <= -(35'(x0) <<< 14);
                cy_reg  <= -(35'(y0) <<< 14);
                ang_reg <= lsb_pkg::ANG_HALF;
            end else begin
                cx_reg  <= 35'(x0) <<< 14;
                cy_reg  <= 35'(y0) <<< 14;
                ang_reg <= '0;
            end
        end else if (cmd.it_run) begin
            if (p_try <= csq4) begin
                q_reg[bsh[4:0]] <= 1'b1;
                p_reg           <= p_try;
                r_reg           <= r_reg + $signed(58'(d_reg) << (bsh + 6'd1));
            end
            if (cmd.it_k < 5'(lsb_pkg::CORDIC_STEPS)) begin
                if (cy_reg > 0) begin
                    cx_reg  <= cx_reg + cy_sh;
                    cy_reg  <= cy_reg - cx_sh;
                    ang_reg <= ang_reg + lsb_pkg::atan_turn(cmd.it_k);
                end else begin
                    cx_reg  <= cx_reg - cy_sh;
                    cy_reg  <= cy_reg + cx_sh;
                    ang_reg <= ang_reg - lsb_pkg::atan_turn(cmd.it_k);
                end
            end
        end
    end

    // case selection for distance and angle
    always_comb begin
        hz    = dz_reg == '0;
        vt    = dx_reg == '0;
        xnz   = x_reg != '0;
        znz   = z_reg != '0;
        cnz   = c_reg != '0;
        dnz   = dot_reg != '0;
        match = pid_reg == code_reg;
        acc   = match && !(hz && vt);
        xabs  = x_reg[23] ? 25'(-(25'(x_reg))) : 25'(x_reg);
        zabs  = z_reg[23] ? 25'(-(25'(z_reg))) : 25'(z_reg);
        ang_sum = ang_reg + lsb_pkg::ANG_ROUND;
        th_cd = ang_sum[31:16];
        if (hz) begin
            mag = zabs;
            th0 = x_reg[23] ? lsb_pkg::TURN_HALF : '0;
            sp  = xnz && znz && (x_reg[23] != z_reg[23]);
            sn  = xnz && znz && (x_reg[23] == z_reg[23]);
            zs  = znz ? z_reg : x_reg;
        end else if (vt) begin
            mag = xabs;
            th0 = (znz && !z_reg[23]) ? lsb_pkg::TURN_HALF : lsb_pkg::TURN_QUARTER;
            sp  = xnz && znz && (x_reg[23] == z_reg[23]);
            sn  = xnz && znz && (x_reg[23] != z_reg[23]);
            zs  = x_reg;
        end else if (cnz) begin
            mag = {1'b0, q_reg};
            th0 = th_cd;
            sp  = dnz && (c_reg[40] == dot_reg[41]);
            sn  = dnz && (c_reg[40] != dot_reg[41]);
            zs  = q_reg[23] ? lsb_pkg::S_MAX_Q : q_reg;
        end else begin
            mag = '0;
            th0 = '0;
            sp  = 1'b0;
            sn  = 1'b0;
            zs  = x_reg;
        end
        smag = (mag > lsb_pkg::S_NEG_LIM) ? lsb_pkg::S_NEG_LIM : mag;
        sneg = 25'd0 - smag;
        if (sp) begin
            s_ev  = sneg[23:0];
            th_ev = th0 + lsb_pkg::TURN_HALF;
        end else if (sn) begin
            s_ev  = (mag > 25'(lsb_pkg::S_MAX_Q)) ? lsb_pkg::S_MAX_Q : mag[23:0];
            th_ev = th0;
        end else begin
            s_ev  = zs;
            th_ev = th0;
        end
        s_ofs   = 25'(s_ev) + $signed(lsb_pkg::S_HALF_RANGE);
        ev_in   = s_ofs[24:17] == '0;
        sb_full = (32'(s_ofs[16:0]) * 32'(S_BINS)) >> 17;
        tb_full = (32'(th_ev) * 32'(THETA_BINS)) >> 16;
        a_ev    = tb_full * 32'(S_BINS) + sb_full;
        rd_ok   = (32'(rs_reg) < 32'(S_BINS)) && (32'(rt_reg) < 32'(THETA_BINS));
        a_rd    = 32'(rt_reg) * 32'(S_BINS) + 32'(rs_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            if (cmd_reg) begin
                acc_reg  <= 1'b0;
                inr_reg  <= 1'b0;
                rdok_reg <= rd_ok;
                s_reg    <= '0;
                th_reg   <= '0;
                sbo_reg  <= rs_reg;
                tbo_reg  <= rt_reg;
                addr_reg <= rd_ok ? a_rd[AW-1:0] : '0;
            end else begin
                acc_reg  <= acc;
                inr_reg  <= acc && ev_in;
                rdok_reg <= 1'b0;
                s_reg    <= acc ? s_ev : '0;
                th_reg   <= acc ? th_ev : '0;
                sbo_reg  <= (acc && ev_in) ? sb_full[8:0] : '0;
                tbo_reg  <= acc ? tb_full[8:0] : '0;
                addr_reg <= (acc && ev_in) ? a_ev[AW-1:0] : '0;
            end
        end
    end

    // count memory: clearing sweep after reset, one read port, one write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_wr && clr_addr_reg != AW'(DEPTH - 1)) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign cnt_new = (rdata_reg == {COUNT_WIDTH{1'b1}}) ? rdata_reg : rdata_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.commit && inr_reg) begin
            mem[addr_reg] <= cnt_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_accepted    <= acc_reg;
            out_s_value     <= s_reg;
            out_theta_value <= th_reg;
            out_s_bin       <= sbo_reg;
            out_theta_bin   <= tbo_reg;
            out_in_range    <= inr_reg;
            if (inr_reg) begin
                out_bin_count <= lsb_pkg::OUT_CNT_W'(cnt_new);
            end else if (rdok_reg) begin
                out_bin_count <= lsb_pkg::OUT_CNT_W'(rdata_reg);
            end else begin
                out_bin_count <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign stat.is_read  = cmd_reg;
    assign stat.clr_last = clr_addr_reg == AW'(DEPTH - 1);
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

// ===== hdl/line_to_sinogram_binner_top.sv =====
// Sinogram binner for list-mode line events.
// Slave stream: s_tuser selects the request (0 bins an event, 1 reads one bin);
// s_tdata carries the event or the bin address. Master stream: one result per
// request, the accepted and in-range flags in m_tuser, values in m_tdata.
// Configuration: cfg_wr_en writes the particle code; write it only while idle.
// An event passes from acceptance through the 11-step shared 25x25 multiplier
// sequence and the 24-step distance root, whose iterations run alongside the
// 20-step angle CORDIC, before the next request is taken. A bin read skips these
// steps and waits only on the registered count memory read. One request is in
// work at a time.
// Reset: the particle code returns to 22 and a clearing pass writes zero to
// all S_BINS*THETA_BINS bins (262144 by default), one a cycle;
// s_tready stays low until it ends.
// Receiver stall: the result holds in the output register; one further
// request is taken and worked, then waits until the register is free.
module line_to_sinogram_binner_top #(
    parameter int S_BINS      = lsb_pkg::S_BINS_DEF,
    parameter int THETA_BINS  = lsb_pkg::THETA_BINS_DEF,
    parameter int COUNT_WIDTH = lsb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lsb_pkg::PID_W-1:0]           cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // particle_id, pos_x, pos_z, dir_x, dir_z, read_s_bin, read_theta_bin
    input  logic [lsb_pkg::IN_TDATA_W-1:0]      s_tdata,
    // command
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // s_value, theta_value, s_bin, theta_bin, bin_count
    output logic [lsb_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // accepted, in_range
    output logic [1:0]                          m_tuser
);

    lsb_pkg::dp_cmd_t  cmd;
    lsb_pkg::dp_stat_t stat;

    logic                                 o_accepted, o_in_range;
    logic signed [lsb_pkg::POS_W-1:0]     o_s_value;
    logic [lsb_pkg::THETA_W-1:0]          o_theta_value;
    logic [lsb_pkg::BIN_W-1:0]            o_s_bin, o_theta_bin;
    logic [lsb_pkg::OUT_CNT_W-1:0]        o_bin_count;

    lsb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // unpack the request fields, lowest bits first
    lsb_dp #(
        .S_BINS      (S_BINS),
        .THETA_BINS  (THETA_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .cmd               (cmd),
        .stat              (stat),
        .in_command        (s_tuser[0]),
        .in_particle_id    (s_tdata[31:0]),
        .in_pos_x          ($signed(s_tdata[55:32])),
        .in_pos_z          ($signed(s_tdata[79:56])),
        .in_dir_x          ($signed(s_tdata[95:80])),
        .in_dir_z          ($signed(s_tdata[111:96])),
        .in_read_s_bin     (s_tdata[120:112]),
        .in_read_theta_bin (s_tdata[129:121]),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_accepted      (o_accepted),
        .out_s_value       (o_s_value),
        .out_theta_value   (o_theta_value),
        .out_s_bin         (o_s_bin),
        .out_theta_bin     (o_theta_bin),
        .out_in_range      (o_in_range),
        .out_bin_count     (o_bin_count)
    );

    // pack the result, padding to whole bytes
    assign m_tdata = {6'd0, o_bin_count, o_theta_bin, o_s_bin, o_theta_value, o_s_value};
    assign m_tuser = {o_in_range, o_accepted};

endmodule

// ===== bench/line_to_sinogram_binner_checker.sv =====
`timescale 1ns / 1ps

module line_to_sinogram_binner_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lsb_pkg::PID_W-1:0]          cfg_wr_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [lsb_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [0:0]                         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [lsb_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic [1:0]                         m_tuser,
    output int                                 fail_count,
    output int                                 pending,
    output logic [8:0]                         last_hit_s,
    output logic [8:0]                         last_hit_theta
);

    typedef struct packed {
        logic        accepted;
        logic        in_range;
        logic [23:0] s_value;
        logic [15:0] theta_value;
        logic [8:0]  s_bin;
        logic [8:0]  theta_bin;
        logic [31:0] bin_count;
    } bin_result_t;

    localparam logic [31:0] ARCTAN [20] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
    };

    logic [31:0] code_q;
    logic [31:0] sino [262144];
    bin_result_t awaited [$];

    function automatic logic [15:0] cordic_theta(longint y_in, longint x_in);
        logic [31:0] ang;
        longint x, y, nx, ny;
        ang = 32'h0;
        x = x_in * 16384;
        y = y_in * 16384;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = lsb_pkg::ANG_HALF;
        end
        for (int i = 0; i < 20; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                ang = ang + ARCTAN[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                ang = ang - ARCTAN[i];
            end
            x = nx;
            y = ny;
        end
        ang = ang + lsb_pkg::ANG_ROUND;
        return ang[31:16];
    endfunction

    // nearest q with (2q-1)^2 * d <= 4 c^2
    function automatic longint root_distance(logic [63:0] cabs, logic [63:0] d);
        logic [127:0] rhs, lhs, o, t, q;
        q = '0;
        rhs = cabs;
        rhs = (rhs * rhs) << 2;
        for (int b = 23; b >= 0; b--) begin
            t = q | (128'd1 << b);
            o = 2 * t - 1;
            lhs = o * o * d;
            if (lhs <= rhs) q = t;
        end
        return longint'(q[31:0]);
    endfunction

    function automatic int sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic bin_result_t bin_request(logic cmd, logic [135:0] d);
        bin_result_t r;
        longint x, z, dx, dz, c, mag, zero_s, s, tb, sb;
        logic [15:0] th;
        int side;
        logic [17:0] addr;
        r = '0;
        if (cmd == lsb_pkg::CMD_READ) begin
            r.s_bin = d[120:112];
            r.theta_bin = d[129:121];
            r.bin_count = sino[{d[129:121], d[120:112]}];
            return r;
        end
        x = longint'($signed(d[55:32]));
        z = longint'($signed(d[79:56]));
        dx = longint'($signed(d[95:80]));
        dz = longint'($signed(d[111:96]));
        if (d[31:0] != code_q || (dx == 0 && dz == 0)) return r;
        if (dz == 0) begin
            mag = (z < 0) ? -z : z;
            th = (x >= 0) ? 16'h0 : lsb_pkg::TURN_HALF;
            side = -(sgn(x) * sgn(z));
            zero_s = (z == 0) ? x : z;
        end else if (dx == 0) begin
            mag = (x < 0) ? -x : x;
            th = (z > 0) ? lsb_pkg::TURN_HALF : lsb_pkg::TURN_QUARTER;
            side = sgn(x) * sgn(z);
            zero_s = x;
        end else begin
            c = x * dz - z * dx;
            if (c == 0) begin
                mag = 0;
                th = 16'h0;
                side = 0;
                zero_s = x;
            end else begin
                mag = root_distance((c < 0) ? -c : c, dx * dx + dz * dz);
                side = sgn(c) * sgn(x * dx + z * dz);
                th = (c > 0) ? cordic_theta(dz, -dx) : cordic_theta(-dz, dx);
                zero_s = (mag > 8388607) ? 8388607 : mag;
            end
        end
        if (side > 0) begin
            s = -((mag > 8388608) ? 8388608 : mag);
            th = th + lsb_pkg::TURN_HALF;
        end else if (side < 0) begin
            s = (mag > 8388607) ? 8388607 : mag;
        end else begin
            s = zero_s;
        end
        r.accepted = 1'b1;
        r.s_value = s[23:0];
        r.theta_value = th;
        tb = (longint'(th) * 512) >>> 16;
        r.theta_bin = tb[8:0];
        if (s >= -65536 && s < 65536) begin
            sb = ((s + 65536) * 512) >>> 17;
            addr = {tb[8:0], sb[8:0]};
            if (sino[addr] != 32'hFFFF_FFFF) sino[addr] = sino[addr] + 1;
            r.s_bin = sb[8:0];
            r.in_range = 1'b1;
            r.bin_count = sino[addr];
            last_hit_s = sb[8:0];
            last_hit_theta = tb[8:0];
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        last_hit_s = '0;
        last_hit_theta = '0;
        code_q = lsb_pkg::CODE_RESET;
        foreach (sino[i]) sino[i] = '0;
    end

    assign pending = awaited.size();

    always @(posedge aclk) begin
        bin_result_t want, got;
        if (!aresetn) begin
            code_q = lsb_pkg::CODE_RESET;
        end else begin
            if (cfg_wr_en) code_q = cfg_wr_data;
            if (s_tvalid && s_tready) awaited.push_back(bin_request(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready) begin
                got.accepted = m_tuser[0];
                got.in_range = m_tuser[1];
                got.s_value = m_tdata[23:0];
                got.theta_value = m_tdata[39:24];
                got.s_bin = m_tdata[48:40];
                got.theta_bin = m_tdata[57:49];
                got.bin_count = m_tdata[89:58];
                if (awaited.size() == 0) begin
                    report("unexpected result", got.bin_count, 32'd0);
                end else begin
                    want = awaited.pop_front();
                    if (got.accepted != want.accepted)
                        report("accepted", got.accepted, want.accepted);
                    if (got.in_range != want.in_range)
                        report("in_range", got.in_range, want.in_range);
                    if (got.s_value != want.s_value)
                        report("s_value", got.s_value, want.s_value);
                    if (got.theta_value != want.theta_value)
                        report("theta_value", got.theta_value, want.theta_value);
                    if (got.s_bin != want.s_bin)
                        report("s_bin", got.s_bin, want.s_bin);
                    if (got.theta_bin != want.theta_bin)
                        report("theta_bin", got.theta_bin, want.theta_bin);
                    if (got.bin_count != want.bin_count)
                        report("bin_count", got.bin_count, want.bin_count);
                end
            end
        end
    end

endmodule

// ===== bench/line_to_sinogram_binner_top_test.sv =====
`timescale 1ns / 1ps

module line_to_sinogram_binner_top_test;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 60;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [lsb_pkg::PID_W-1:0]       cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [lsb_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [lsb_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]                      m_tuser;

    int          fail_count;
    int          pending;
    logic [8:0]  last_hit_s;
    logic [8:0]  last_hit_theta;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic [31:0] code_now;
    int          cycles;

    line_to_sinogram_binner_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    line_to_sinogram_binner_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .last_hit_s    (last_hit_s),
        .last_hit_theta(last_hit_theta)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver side: drop tready at random at the rate of the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: fail the run once CYCLE_LIMIT is reached, as when the block stops answering
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("line_to_sinogram_binner_top_test NOT OK");
            $finish;
        end
    end

    // Offer one request and hold it until the block takes it; idle before it at the
    // phase's rate. tvalid stays high for a back-to-back request.
    task automatic send(logic cmd, logic [31:0] pid, logic [23:0] px, logic [23:0] pz,
                        logic [15:0] dx, logic [15:0] dz, logic [8:0] rs, logic [8:0] rt);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, rt, rs, dz, dx, pz, px, pid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic bin_event(logic [31:0] pid, logic [23:0] px, logic [23:0] pz,
                             logic [15:0] dx, logic [15:0] dz);
        send(lsb_pkg::CMD_BIN, pid, px, pz, dx, dz, 9'($urandom), 9'($urandom));
    endtask

    task automatic read_bin(logic [8:0] rs, logic [8:0] rt);
        send(lsb_pkg::CMD_READ, $urandom, 24'($urandom), 24'($urandom),
             16'($urandom), 16'($urandom), rs, rt);
    endtask

    // Hold the sender until every result is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_code(logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        code_now = v;
        @(posedge aclk);
    endtask

    // Mostly well-formed events near the centre, so bins fill and reads find counts
    task automatic random_request(int n);
        int sel;
        logic [23:0] px, pz;
        logic [15:0] dx, dz;
        logic [31:0] pid;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 25) begin
                if ($urandom_range(1)) read_bin(last_hit_s, last_hit_theta);
                else read_bin(9'($urandom), 9'($urandom));
            end else begin
                if ($urandom_range(99) < 75) begin
                    px = 24'($signed($urandom_range(0, 120000)) - 60000);
                    pz = 24'($signed($urandom_range(0, 120000)) - 60000);
                end else begin
                    px = 24'($urandom);
                    pz = 24'($urandom);
                end
                dx = 16'($urandom);
                dz = 16'($urandom);
                case ($urandom_range(9))
                    0: dx = '0;
                    1: dz = '0;
                    2: begin
                        dx = 16'($signed($urandom_range(0, 20)) - 10);
                        dz = 16'($signed($urandom_range(0, 20)) - 10);
                    end
                    default: ;
                endcase
                pid = (sel < 90) ? code_now : $urandom;
                bin_event(pid, px, pz, dx, dz);
            end
        end
    endtask

    initial begin
        cycles      = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = lsb_pkg::CMD_BIN;
        m_tready    = 1'b0;
        code_now    = lsb_pkg::CODE_RESET;
        send_idle_pct = 15;
        recv_idle_pct = 83;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: axis-parallel lines, lines through the origin, extremes
        bin_event(code_now, 24'sd1000, 24'sd2000, 16'sd5, 16'sd0);
        bin_event(code_now, -24'sd1000, -24'sd700, -16'sd3, 16'sd0);
        bin_event(code_now, -24'sd300, 24'sd0, 16'sd9, 16'sd0);
        bin_event(code_now, 24'sd400, 24'sd900, 16'sd0, 16'sd7);
        bin_event(code_now, 24'sd400, -24'sd900, 16'sd0, -16'sd7);
        bin_event(code_now, 24'sd0, 24'sd50, 16'sd0, 16'sd1);
        bin_event(code_now, 24'sd100, 24'sd200, 16'sd1, 16'sd2);
        bin_event(code_now, 24'sd3000, -24'sd1234, 16'sd17, -16'sd40);
        bin_event(code_now, 24'sd3000, -24'sd1234, 16'sd17, -16'sd40);
        read_bin(last_hit_s, last_hit_theta);
        bin_event(code_now, 24'h7FFFFF, 24'h800000, 16'h8000, 16'h7FFF);
        bin_event(code_now, 24'h800000, 24'h800000, 16'h7FFF, 16'h8000);
        bin_event(code_now, 24'h7FFFFF, 24'h7FFFFF, 16'h8000, 16'h8000);
        bin_event(code_now, 24'sd5000, 24'sd6000, 16'sd0, 16'sd0);
        bin_event(32'h8000_0000, 24'sd10, 24'sd10, 16'sd1, 16'sd1);
        bin_event(32'h7FFF_FFFF, 24'sd10, 24'sd10, 16'sd1, 16'sd1);
        bin_event(code_now, 24'sd200000, 24'sd10, 16'sd0, 16'sd3);
        bin_event(code_now, -24'sd65536, 24'sd10, 16'sd0, 16'sd3);
        bin_event(code_now, 24'sd65535, 24'sd10, 16'sd0, 16'sd3);
        read_bin(9'd0, 9'd0);
        read_bin(9'd511, 9'd511);
        read_bin(last_hit_s, last_hit_theta);

        random_request(100);
        // hold the sender until every outstanding result is in
        drain();
        random_request(20);
        drain();

        // Swap the idle rates and move the code to 7FFF_FFFF
        write_code(32'h7FFF_FFFF);
        send_idle_pct = 83;
        recv_idle_pct = 15;
        random_request(120);
        drain();

        write_code(32'h8000_0000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_request(120);
        drain();

        write_code($urandom);
        random_request(120);
        drain();

        if (fail_count == 0) begin
            $display("line_to_sinogram_binner_top_test OK");
        end else begin
            $display("line_to_sinogram_binner_top_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lsb_pkg.sv
hdl/lsb_ctrl.sv
hdl/lsb_dp.sv
hdl/line_to_sinogram_binner_top.sv
bench/line_to_sinogram_binner_checker.sv
bench/line_to_sinogram_binner_top_test.sv
